// File: sv/trilk_pkg.sv
// ----------------------------------------------------------------------------
// trilk_pkg: shared types and codes of the takeoff readiness interlock
// Operation, reason, result kind and register index codes, plus payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package trilk_pkg;

  localparam int NUM_INPUTS = 6;
  localparam int AGE_W      = 16;
  localparam int TOTAL_W    = 32;

  typedef logic [2:0]        op_t;
  typedef logic signed [15:0] sample_t;
  typedef logic [3:0]        reason_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [2:0]        cfg_idx_t;
  typedef logic [15:0]       cfg_data_t;

  // operation codes
  localparam op_t OP_TICK      = 3'd0;
  localparam op_t OP_VEH_CHG   = 3'd1;
  localparam op_t OP_VEH_VALID = 3'd2;
  localparam op_t OP_BASE_CHG  = 3'd3;
  localparam op_t OP_BASE_VALID = 3'd4;
  localparam op_t OP_WIND      = 3'd5;
  localparam op_t OP_WIND_VALID = 3'd6;
  localparam op_t OP_REQUEST   = 3'd7;

  // reason codes, in priority order
  localparam reason_t RSN_READY        = 4'd0;
  localparam reason_t RSN_VEH_STALE    = 4'd1;
  localparam reason_t RSN_VEH_INVALID  = 4'd2;
  localparam reason_t RSN_VEH_LOW      = 4'd3;
  localparam reason_t RSN_BASE_STALE   = 4'd4;
  localparam reason_t RSN_BASE_INVALID = 4'd5;
  localparam reason_t RSN_BASE_LOW     = 4'd6;
  localparam reason_t RSN_WIND_STALE   = 4'd7;
  localparam reason_t RSN_WIND_INVALID = 4'd8;
  localparam reason_t RSN_WIND_HIGH    = 4'd9;
  localparam reason_t RSN_NONE         = 4'd10;

  // result kinds
  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t CFG_MIN_VEH    = 3'd0;
  localparam cfg_idx_t CFG_MIN_BASE   = 3'd1;
  localparam cfg_idx_t CFG_MAX_WIND   = 3'd2;
  localparam cfg_idx_t CFG_MAX_AGE    = 3'd3;
  localparam cfg_idx_t CFG_STAT_PER   = 3'd4;

  typedef struct packed {
    logic    result_kind;
    logic    ready_res;
    reason_t reason_code;
    total_t  approved_total;
    total_t  rejected_total;
    logic    last_of_run;
  } res_t;

endpackage

`default_nettype wire

// File: sv/trilk_if.sv
// ----------------------------------------------------------------------------
// trilk_if: valid/ready channels of the takeoff readiness interlock
// Input item channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface trilk_in_if;
  logic              valid;
  logic              ready;
  trilk_pkg::op_t     operation;
  trilk_pkg::sample_t sample_value;

  modport source(output valid, output operation, output sample_value, input ready);
  modport sink(input valid, input operation, input sample_value, output ready);
endinterface

interface trilk_out_if;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic              ready_res;
  trilk_pkg::reason_t reason_code;
  trilk_pkg::total_t  approved_total;
  trilk_pkg::total_t  rejected_total;
  logic              last_of_run;

  modport source(output valid, output result_kind, output ready_res, output reason_code,
                 output approved_total, output rejected_total, output last_of_run,
                 input ready);
  modport sink(input valid, input result_kind, input ready_res, input reason_code,
               input approved_total, input rejected_total, input last_of_run,
               output ready);
endinterface

`default_nettype wire

// File: sv/takeoff_readiness_interlock_top.sv
// ----------------------------------------------------------------------------
// takeoff_readiness_interlock_top: takeoff readiness safety interlock
// Tracks sensor freshness and limits, answers takeoff requests on each tick,
// and posts status results on period expiry or a change of readiness or reason.
// ----------------------------------------------------------------------------
// Items enter an input register and are worked from it in one pass.
// Sensor updates and requests are absorbed at one per cycle, unless a
// waiting tick holds the input register, and give no result. A tick computes
// the ages, the prioritized reason code and the decision and status results
// in that same pass and pushes up to two results into a two-entry result
// queue, which feeds the out_ch port one transfer per cycle while out_ch.ready
// is high. A tick is worked only when the queue is empty or its last entry
// leaves in that cycle, so back-pressure on the result port sets the tick
// rate. A result passes the input register and the result queue on its way
// to out_ch. Configuration is written through cfg_we/cfg_index/cfg_wdata and
// takes effect on the next worked tick; writes to unused indexes are dropped.
`default_nettype none

module takeoff_readiness_interlock_top #(
  parameter int COUNTER_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  trilk_in_if.sink               in_ch,
  trilk_out_if.source            out_ch,
  input  wire                    cfg_we,
  input  wire trilk_pkg::cfg_idx_t  cfg_index,
  input  wire trilk_pkg::cfg_data_t cfg_wdata
);

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  // configuration registers
  logic [9:0]       min_veh_r;
  logic [9:0]       min_base_r;
  logic [14:0]      max_wind_r;
  trilk_pkg::age_t  max_age_r;
  trilk_pkg::age_t  stat_per_r;

  // input register
  logic               iv_r;
  trilk_pkg::op_t     op_r;
  trilk_pkg::sample_t sv_r;

  // interlock state
  trilk_pkg::age_t    age_r  [trilk_pkg::NUM_INPUTS];
  logic [trilk_pkg::NUM_INPUTS-1:0] seen_r;
  trilk_pkg::sample_t veh_r;
  trilk_pkg::sample_t base_r;
  trilk_pkg::sample_t wind_r;
  logic [2:0]         vflags_r;
  logic               pend_r;
  logic               prev_ready_r;
  trilk_pkg::reason_t prev_reason_r;
  trilk_pkg::age_t    tss_r;
  cnt_t               appr_r;
  cnt_t               rej_r;

  // result queue, entry 0 is the head
  trilk_pkg::res_t    q_r [2];
  logic [1:0]         q_cnt_r;

  // tick computation
  trilk_pkg::age_t    age_inc [trilk_pkg::NUM_INPUTS];
  logic [trilk_pkg::NUM_INPUTS-1:0] fresh;
  trilk_pkg::age_t    tss_inc;
  trilk_pkg::reason_t reason;
  logic               ready;
  logic               stat_due;
  cnt_t               appr_nxt;
  cnt_t               rej_nxt;
  trilk_pkg::res_t    dec_res;
  trilk_pkg::res_t    stat_res;

  logic               pop;
  logic               q_room;
  logic               is_tick;
  logic               proc_fire;
  logic               tick_fire;
  logic               flag;

  // --------------------------------------------------------------------------
  // Handshakes: the input register refills whenever its item is worked.
  // --------------------------------------------------------------------------
  assign pop       = out_ch.valid && out_ch.ready;
  assign q_room    = (q_cnt_r == 2'd0) || (q_cnt_r == 2'd1 && pop);
  assign is_tick   = (op_r == trilk_pkg::OP_TICK);
  assign proc_fire = iv_r && (!is_tick || q_room);
  assign tick_fire = iv_r && is_tick && q_room;
  assign flag      = (sv_r != 16'sd0);

  assign in_ch.ready = !iv_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      iv_r <= 1'b1;
    end else if (proc_fire) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r <= in_ch.operation;
      sv_r <= in_ch.sample_value;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_veh_r  <= 10'd300;
      min_base_r <= 10'd150;
      max_wind_r <= 15'd400;
      max_age_r  <= 16'd30;
      stat_per_r <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        trilk_pkg::CFG_MIN_VEH:  min_veh_r  <= cfg_wdata[9:0];
        trilk_pkg::CFG_MIN_BASE: min_base_r <= cfg_wdata[9:0];
        trilk_pkg::CFG_MAX_WIND: max_wind_r <= cfg_wdata[14:0];
        trilk_pkg::CFG_MAX_AGE:  max_age_r  <= cfg_wdata;
        trilk_pkg::CFG_STAT_PER: stat_per_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tick pass: advance ages, form the reason code, build both results.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < trilk_pkg::NUM_INPUTS; i++) begin
      age_inc[i] = (age_r[i] != '1) ? age_r[i] + 16'd1 : age_r[i];
      fresh[i]   = seen_r[i] && (age_inc[i] <= max_age_r);
    end
    tss_inc = (tss_r != '1) ? tss_r + 16'd1 : tss_r;

    // stale, then invalid, then out of limits, vehicle first, wind last
    if (!fresh[0] || !fresh[1]) begin
      reason = trilk_pkg::RSN_VEH_STALE;
    end else if (!vflags_r[0]) begin
      reason = trilk_pkg::RSN_VEH_INVALID;
    end else if (veh_r < $signed({6'd0, min_veh_r})) begin
      reason = trilk_pkg::RSN_VEH_LOW;
    end else if (!fresh[2] || !fresh[3]) begin
      reason = trilk_pkg::RSN_BASE_STALE;
    end else if (!vflags_r[1]) begin
      reason = trilk_pkg::RSN_BASE_INVALID;
    end else if (base_r < $signed({6'd0, min_base_r})) begin
      reason = trilk_pkg::RSN_BASE_LOW;
    end else if (!fresh[4] || !fresh[5]) begin
      reason = trilk_pkg::RSN_WIND_STALE;
    end else if (!vflags_r[2]) begin
      reason = trilk_pkg::RSN_WIND_INVALID;
    end else if (wind_r[15] || (wind_r > $signed({1'b0, max_wind_r}))) begin
      reason = trilk_pkg::RSN_WIND_HIGH;
    end else begin
      reason = trilk_pkg::RSN_READY;
    end
    ready = (reason == trilk_pkg::RSN_READY);

    appr_nxt = appr_r;
    rej_nxt  = rej_r;
    if (pend_r) begin
      if (ready) begin
        if (appr_r != '1) appr_nxt = appr_r + 1'b1;
      end else begin
        if (rej_r != '1) rej_nxt = rej_r + 1'b1;
      end
    end

    stat_due = (tss_inc >= stat_per_r) || (ready != prev_ready_r) ||
               (reason != prev_reason_r);

    dec_res.result_kind    = trilk_pkg::KIND_DECISION;
    dec_res.ready_res      = ready;
    dec_res.reason_code    = reason;
    dec_res.approved_total = trilk_pkg::TOTAL_W'(appr_nxt);
    dec_res.rejected_total = trilk_pkg::TOTAL_W'(rej_nxt);
    dec_res.last_of_run    = !stat_due;

    stat_res             = dec_res;
    stat_res.result_kind = trilk_pkg::KIND_STATUS;
    stat_res.last_of_run = 1'b1;
  end

  // --------------------------------------------------------------------------
  // State update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < trilk_pkg::NUM_INPUTS; i++) begin
        age_r[i] <= '0;
      end
      seen_r        <= '0;
      veh_r         <= '0;
      base_r        <= '0;
      wind_r        <= '0;
      vflags_r      <= '0;
      pend_r        <= 1'b0;
      prev_ready_r  <= 1'b0;
      prev_reason_r <= trilk_pkg::RSN_NONE;
      tss_r         <= '1;
      appr_r        <= '0;
      rej_r         <= '0;
    end else if (tick_fire) begin
      for (int i = 0; i < trilk_pkg::NUM_INPUTS; i++) begin
        age_r[i] <= age_inc[i];
      end
      appr_r <= appr_nxt;
      rej_r  <= rej_nxt;
      pend_r <= 1'b0;
      if (stat_due) begin
        tss_r         <= '0;
        prev_ready_r  <= ready;
        prev_reason_r <= reason;
      end else begin
        tss_r <= tss_inc;
      end
    end else if (proc_fire) begin
      // restart the age of the updated input
      for (int i = 0; i < trilk_pkg::NUM_INPUTS; i++) begin
        if (op_r == 3'(i + 1)) begin
          age_r[i]  <= '0;
          seen_r[i] <= 1'b1;
        end
      end
      case (op_r)
        trilk_pkg::OP_VEH_CHG:    veh_r       <= sv_r;
        trilk_pkg::OP_VEH_VALID:  vflags_r[0] <= flag;
        trilk_pkg::OP_BASE_CHG:   base_r      <= sv_r;
        trilk_pkg::OP_BASE_VALID: vflags_r[1] <= flag;
        trilk_pkg::OP_WIND:       wind_r      <= sv_r;
        trilk_pkg::OP_WIND_VALID: vflags_r[2] <= flag;
        trilk_pkg::OP_REQUEST: begin
          if (flag) pend_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: load on a worked tick, otherwise advance on each transfer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else if (tick_fire) begin
      q_cnt_r <= {1'b0, pend_r} + {1'b0, stat_due};
    end else if (pop) begin
      q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      q_r[0] <= pend_r ? dec_res : stat_res;
      q_r[1] <= stat_res;
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end
  end

  assign out_ch.valid          = (q_cnt_r != 2'd0);
  assign out_ch.result_kind    = q_r[0].result_kind;
  assign out_ch.ready_res      = q_r[0].ready_res;
  assign out_ch.reason_code    = q_r[0].reason_code;
  assign out_ch.approved_total = q_r[0].approved_total;
  assign out_ch.rejected_total = q_r[0].rejected_total;
  assign out_ch.last_of_run    = q_r[0].last_of_run;

`ifndef SYNTH
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_kind == trilk_pkg::KIND_STATUS |-> out_ch.last_of_run)
    else $error("status result not marked last of run");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r == 2'd2 |-> !q_r[0].last_of_run && q_r[0].result_kind == trilk_pkg::KIND_DECISION
                        && q_r[1].result_kind == trilk_pkg::KIND_STATUS)
    else $error("two queued results not a decision then a status");

  a_ready_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.ready_res == (out_ch.reason_code == trilk_pkg::RSN_READY))
    else $error("ready flag disagrees with reason code");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> !pend_r)
    else $error("request still pending after a worked tick");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the takeoff readiness interlock
// Drives sensor updates, requests and ticks with random pacing on both
// channels, predicts every decision and status result, and checks each one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_GUARD  = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int SOAK_TICKS  = 40;

  // --------------------------------------------------------------------------
  // Predictor and result check. Keeps its own copy of the limits and of the
  // sensor state, and queues the results each tick must produce.
  // --------------------------------------------------------------------------
  class interlock_checker;
    logic [9:0]         min_veh_chg;
    logic [9:0]         min_base_chg;
    logic [14:0]        max_wind_spd;
    trilk_pkg::age_t    max_age;
    trilk_pkg::age_t    status_every;

    trilk_pkg::age_t    age [trilk_pkg::NUM_INPUTS];
    bit                 seen [trilk_pkg::NUM_INPUTS];
    trilk_pkg::sample_t veh_chg;
    trilk_pkg::sample_t base_chg;
    trilk_pkg::sample_t wind_spd;
    bit [2:0]           flags;
    bit                 request_waiting;
    bit                 last_ready;
    trilk_pkg::reason_t last_reason;
    trilk_pkg::age_t    since_status;
    trilk_pkg::total_t  approvals;
    trilk_pkg::total_t  rejections;

    trilk_pkg::res_t    reports_due[$];
    int                 errors;

    function new();
      min_veh_chg     = 10'd300;
      min_base_chg    = 10'd150;
      max_wind_spd    = 15'd400;
      max_age         = 16'd30;
      status_every    = 16'd10;
      foreach (age[i]) begin
        age[i]  = '0;
        seen[i] = 1'b0;
      end
      veh_chg         = '0;
      base_chg        = '0;
      wind_spd        = '0;
      flags           = '0;
      request_waiting = 1'b0;
      last_ready      = 1'b0;
      last_reason     = trilk_pkg::RSN_NONE;
      since_status    = '1;
      approvals       = '0;
      rejections      = '0;
      errors          = 0;
    endfunction

    function void write_reg(trilk_pkg::cfg_idx_t idx, trilk_pkg::cfg_data_t d);
      case (idx)
        trilk_pkg::CFG_MIN_VEH:  min_veh_chg  = d[9:0];
        trilk_pkg::CFG_MIN_BASE: min_base_chg = d[9:0];
        trilk_pkg::CFG_MAX_WIND: max_wind_spd = d[14:0];
        trilk_pkg::CFG_MAX_AGE:  max_age      = d;
        trilk_pkg::CFG_STAT_PER: status_every = d;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return reports_due.size();
    endfunction

    function bit fresh(int i);
      return seen[i] && (age[i] <= max_age);
    endfunction

    function trilk_pkg::reason_t reason_now();
      int vc;
      int bc;
      int ws;
      vc = veh_chg;
      bc = base_chg;
      ws = wind_spd;
      if (!fresh(0) || !fresh(1)) return trilk_pkg::RSN_VEH_STALE;
      if (!flags[0]) return trilk_pkg::RSN_VEH_INVALID;
      if (vc < int'(min_veh_chg)) return trilk_pkg::RSN_VEH_LOW;
      if (!fresh(2) || !fresh(3)) return trilk_pkg::RSN_BASE_STALE;
      if (!flags[1]) return trilk_pkg::RSN_BASE_INVALID;
      if (bc < int'(min_base_chg)) return trilk_pkg::RSN_BASE_LOW;
      if (!fresh(4) || !fresh(5)) return trilk_pkg::RSN_WIND_STALE;
      if (!flags[2]) return trilk_pkg::RSN_WIND_INVALID;
      if (ws < 0 || ws > int'(max_wind_spd)) return trilk_pkg::RSN_WIND_HIGH;
      return trilk_pkg::RSN_READY;
    endfunction

    function trilk_pkg::res_t make_report(logic kind, bit rdy, trilk_pkg::reason_t r,
                                          bit last);
      trilk_pkg::res_t t;
      t.result_kind    = kind;
      t.ready_res      = rdy;
      t.reason_code    = r;
      t.approved_total = approvals;
      t.rejected_total = rejections;
      t.last_of_run    = last;
      return t;
    endfunction

    // Advance the model by one accepted input transfer.
    function void note_item(trilk_pkg::op_t op, trilk_pkg::sample_t v);
      bit                 flag;
      bit                 rdy;
      bit                 has_dec;
      bit                 has_stat;
      trilk_pkg::reason_t r;
      flag = (v != 0);
      case (op)
        trilk_pkg::OP_VEH_CHG: begin
          veh_chg = v; age[0] = '0; seen[0] = 1'b1;
        end
        trilk_pkg::OP_VEH_VALID: begin
          flags[0] = flag; age[1] = '0; seen[1] = 1'b1;
        end
        trilk_pkg::OP_BASE_CHG: begin
          base_chg = v; age[2] = '0; seen[2] = 1'b1;
        end
        trilk_pkg::OP_BASE_VALID: begin
          flags[1] = flag; age[3] = '0; seen[3] = 1'b1;
        end
        trilk_pkg::OP_WIND: begin
          wind_spd = v; age[4] = '0; seen[4] = 1'b1;
        end
        trilk_pkg::OP_WIND_VALID: begin
          flags[2] = flag; age[5] = '0; seen[5] = 1'b1;
        end
        trilk_pkg::OP_REQUEST: begin
          if (flag) request_waiting = 1'b1;
        end
        trilk_pkg::OP_TICK: begin
          foreach (age[i]) if (age[i] != '1) age[i]++;
          if (since_status != '1) since_status++;
          r   = reason_now();
          rdy = (r == trilk_pkg::RSN_READY);
          has_dec = request_waiting;
          if (request_waiting) begin
            request_waiting = 1'b0;
            if (rdy) begin
              if (approvals != '1) approvals++;
            end else begin
              if (rejections != '1) rejections++;
            end
          end
          has_stat = (since_status >= status_every) || (rdy != last_ready) ||
                     (r != last_reason);
          if (has_dec)
            reports_due.push_back(make_report(trilk_pkg::KIND_DECISION, rdy, r, !has_stat));
          if (has_stat) begin
            reports_due.push_back(make_report(trilk_pkg::KIND_STATUS, rdy, r, 1'b1));
            since_status = '0;
            last_ready   = rdy;
            last_reason  = r;
          end
        end
        default: ;
      endcase
    endfunction

    task log_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    // Compare one result transfer against the oldest prediction.
    task check_report(trilk_pkg::res_t got);
      trilk_pkg::res_t want;
      if (reports_due.size() == 0) begin
        log_mismatch($sformatf("unexpected result kind=%0d reason=%0d",
                               got.result_kind, got.reason_code));
        return;
      end
      want = reports_due.pop_front();
      if (got.result_kind !== want.result_kind)
        log_mismatch($sformatf("result_kind %0d, want %0d", got.result_kind,
                               want.result_kind));
      if (got.ready_res !== want.ready_res)
        log_mismatch($sformatf("ready_res %0d, want %0d", got.ready_res, want.ready_res));
      if (got.reason_code !== want.reason_code)
        log_mismatch($sformatf("reason_code %0d, want %0d", got.reason_code,
                               want.reason_code));
      if (got.approved_total !== want.approved_total)
        log_mismatch($sformatf("approved_total %0d, want %0d", got.approved_total,
                               want.approved_total));
      if (got.rejected_total !== want.rejected_total)
        log_mismatch($sformatf("rejected_total %0d, want %0d", got.rejected_total,
                               want.rejected_total));
      if (got.last_of_run !== want.last_of_run)
        log_mismatch($sformatf("last_of_run %0d, want %0d", got.last_of_run,
                               want.last_of_run));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  trilk_pkg::cfg_idx_t   cfg_index;
  trilk_pkg::cfg_data_t  cfg_wdata;

  trilk_in_if  in_ch();
  trilk_out_if out_ch();

  interlock_checker ledger = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  takeoff_readiness_interlock_top #(
    .COUNTER_BITS(32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, with long stretches of steady ready.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int stretch;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      repeat (stretch) @(posedge clk);
    end
  end

  // Sample each result transfer at the edge and hand it to the checker.
  always @(posedge clk) begin
    trilk_pkg::res_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.result_kind    = out_ch.result_kind;
      got.ready_res      = out_ch.ready_res;
      got.reason_code    = out_ch.reason_code;
      got.approved_total = out_ch.approved_total;
      got.rejected_total = out_ch.rejected_total;
      got.last_of_run    = out_ch.last_of_run;
      ledger.check_report(got);
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item and hold it until the transfer; called and returns at an edge.
  // Keep valid high into the next item when there is no gap.
  task automatic send_item(trilk_pkg::op_t op, trilk_pkg::sample_t v, bit pace = 1'b1);
    int gap;
    gap = pace ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.sample_value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ledger.note_item(op, v);
  endtask

  // Drop valid, let every predicted result drain, then give a tick that
  // produced nothing time to finish inside the block.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic put_reg(trilk_pkg::cfg_idx_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= trilk_pkg::cfg_data_t'(val);
    @(posedge clk);
    ledger.write_reg(idx, trilk_pkg::cfg_data_t'(val));
  endtask

  // Rewrite all five limits while the block is idle.
  task automatic load_settings(int mv, int mb, int mw, int ma, int sp);
    settle();
    put_reg(trilk_pkg::CFG_MIN_VEH, mv);
    put_reg(trilk_pkg::CFG_MIN_BASE, mb);
    put_reg(trilk_pkg::CFG_MAX_WIND, mw);
    put_reg(trilk_pkg::CFG_MAX_AGE, ma);
    put_reg(trilk_pkg::CFG_STAT_PER, sp);
    cfg_we <= 1'b0;
  endtask

  // Charge just around its limit, so low and ok both show up.
  function automatic trilk_pkg::sample_t near(int limit);
    return trilk_pkg::sample_t'(limit + $urandom_range(0, 40) - 8);
  endfunction

  // Mostly plausible sensor values; sometimes anything at all.
  function automatic trilk_pkg::sample_t sane_value(trilk_pkg::op_t op);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return trilk_pkg::sample_t'($urandom);
    case (op)
      trilk_pkg::OP_VEH_CHG:  return near(ledger.min_veh_chg);
      trilk_pkg::OP_BASE_CHG: return near(ledger.min_base_chg);
      trilk_pkg::OP_WIND: begin
        if (roll < 88) return trilk_pkg::sample_t'($urandom_range(0, ledger.max_wind_spd));
        return trilk_pkg::sample_t'(ledger.max_wind_spd + $urandom_range(1, 30));
      end
      default: begin
        // validity flags: mostly true with an arbitrary nonzero pattern
        if (roll < 85) return trilk_pkg::sample_t'($urandom_range(1, 65535));
        return trilk_pkg::sample_t'(0);
      end
    endcase
  endfunction

  // Random traffic: mostly sensor refreshes followed by tick bursts with
  // requests, the rest raw noise. Drain fully now and then.
  task automatic run_phase(int items);
    int              sent;
    int              roll;
    int              burst;
    int              start;
    trilk_pkg::op_t  op;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) settle();
      if (roll < 20) begin
        send_item(trilk_pkg::op_t'($urandom_range(0, 7)), trilk_pkg::sample_t'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          start = $urandom_range(0, 5);
          for (int k = 0; k < trilk_pkg::NUM_INPUTS; k++) begin
            op = trilk_pkg::op_t'(1 + (start + k) % trilk_pkg::NUM_INPUTS);
            send_item(op, sane_value(op));
          end
          sent += trilk_pkg::NUM_INPUTS;
        end else begin
          op = trilk_pkg::op_t'($urandom_range(1, 6));
          send_item(op, sane_value(op));
          sent++;
        end
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 9) < 4) begin
            send_item(trilk_pkg::OP_REQUEST,
                      ($urandom_range(0, 9) == 0) ? trilk_pkg::sample_t'(0) :
                      trilk_pkg::sample_t'($urandom_range(1, 65535)));
            sent++;
          end
          send_item(trilk_pkg::OP_TICK, trilk_pkg::sample_t'($urandom));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.operation    = trilk_pkg::OP_TICK;
    in_ch.sample_value = '0;
    cfg_we             = 1'b0;
    cfg_index          = trilk_pkg::CFG_MIN_VEH;
    cfg_wdata          = '0;

    // Hold reset low once, at the start.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset limits.
    send_item(trilk_pkg::OP_TICK, 16'sh0000);      // nothing received yet: stale, first status
    send_item(trilk_pkg::OP_REQUEST, 16'sh0000);   // zero request is dropped
    send_item(trilk_pkg::OP_TICK, 16'sh7FFF);      // tick ignores its value
    send_item(trilk_pkg::OP_REQUEST, 16'shFFFF);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);      // reject while stale
    send_item(trilk_pkg::OP_VEH_CHG, 16'sh8000);   // most negative charge
    send_item(trilk_pkg::OP_VEH_VALID, 16'sh0000);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);      // vehicle invalid
    send_item(trilk_pkg::OP_VEH_VALID, 16'sh8000); // any nonzero pattern is true
    send_item(trilk_pkg::OP_TICK, 16'sh0000);      // negative charge reads as low
    send_item(trilk_pkg::OP_VEH_CHG, 16'sh7FFF);
    send_item(trilk_pkg::OP_BASE_CHG, 16'sd149);
    send_item(trilk_pkg::OP_BASE_VALID, 16'sd1);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);      // base just below its limit
    send_item(trilk_pkg::OP_BASE_CHG, 16'sd150);
    send_item(trilk_pkg::OP_WIND, 16'shFFFF);      // negative wind reads as high
    send_item(trilk_pkg::OP_WIND_VALID, 16'sh7FFF);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);
    send_item(trilk_pkg::OP_WIND, 16'sd400);       // wind exactly at its limit
    send_item(trilk_pkg::OP_REQUEST, 16'sh5555);
    send_item(trilk_pkg::OP_TICK, 16'shAAAA);      // approve
    send_item(trilk_pkg::OP_WIND, 16'sd401);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);
    send_item(trilk_pkg::OP_WIND_VALID, 16'sh0000);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);
    send_item(trilk_pkg::OP_BASE_VALID, 16'sh0000);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);

    // Zero age limit (always stale) and zero period (status every tick).
    load_settings(0, 0, 0, 0, 0);
    run_phase(PHASE_ITEMS - 40);
    // Near the upper extremes: strict charges, loosest wind, ages and period.
    load_settings(1000, 1000, 32767, 65535, 65535);
    run_phase(PHASE_ITEMS);
    // Shortest nonzero age and period.
    load_settings(1000, 0, 32767, 1, 1);
    run_phase(PHASE_ITEMS);
    repeat (2) begin
      load_settings($urandom_range(0, 1000), $urandom_range(0, 1000),
                    $urandom_range(0, 32767), $urandom_range(1, 12),
                    $urandom_range(1, 20));
      run_phase(PHASE_ITEMS);
    end
    load_settings(300, 150, 400, 30, 10);
    run_phase(PHASE_ITEMS);

    // Staleness: go ready, then tick past the age limit without updates;
    // the inputs must turn stale and stay stale.
    load_settings(300, 150, 400, 20, 65535);
    send_item(trilk_pkg::OP_VEH_CHG, 16'sd500);
    send_item(trilk_pkg::OP_VEH_VALID, 16'sd1);
    send_item(trilk_pkg::OP_BASE_CHG, 16'sd500);
    send_item(trilk_pkg::OP_BASE_VALID, 16'sd1);
    send_item(trilk_pkg::OP_WIND, 16'sd100);
    send_item(trilk_pkg::OP_WIND_VALID, 16'sd1);
    for (int k = 0; k < SOAK_TICKS; k++) send_item(trilk_pkg::OP_TICK, 16'sh0000, 1'b0);
    send_item(trilk_pkg::OP_REQUEST, 16'sd1);
    send_item(trilk_pkg::OP_TICK, 16'sh0000);

    // Drain and close out.
    settle();
    repeat (IDLE_GUARD) @(posedge clk);
    if (ledger.outstanding() != 0)
      ledger.log_mismatch($sformatf("%0d results never arrived", ledger.outstanding()));
    if (ledger.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
